[sv/lmsp_pkg.sv]
// Shared types, constants and helper functions of the LMS load predictor.
package lmsp_pkg;

    localparam int FRAC                 = 32;
    localparam int UTIL_FRAC_BITS_DEF   = 15;
    localparam int WEIGHT_WIDTH_DEF     = 48;
    localparam int LR_FRAC              = 16;
    localparam int SQ_SHIFT             = 36;
    localparam int Q_BITS               = 72;

    localparam logic signed [63:0] CAP  = 64'sh1000_0000_0000_0000;
    localparam logic signed [63:0] ONE  = 64'sh0000_0001_0000_0000;
    localparam logic [63:0] NS_PER_S    = 64'd1000000000;
    localparam logic [63:0] MEM_SCALE   = 64'd1000;

    localparam logic [7:0]  REG_TOTAL_MEM  = 8'd0;
    localparam logic [7:0]  REG_LEARN_RATE = 8'd1;
    localparam logic [31:0] TOTAL_MEM_RST  = 32'd1;
    localparam logic [15:0] LEARN_RATE_RST = 16'd655;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_POST,
        ST_APPLY,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        STEP_P_CPU,
        STEP_P_RAM,
        STEP_P_BW,
        STEP_T,
        STEP_D_CPU,
        STEP_D_RAM,
        STEP_D_BW,
        STEP_DEN_BW,
        STEP_DEN_RAM,
        STEP_Q_CPU,
        STEP_Q_RAM,
        STEP_Q_BW,
        STEP_SQ_BW,
        STEP_SQ_RAM,
        STEP_SQ_CPU
    } step_t;

    function automatic step_t next_step(input step_t s);
        step_t n;
        unique case (s)
            STEP_P_CPU:   n = STEP_P_RAM;
            STEP_P_RAM:   n = STEP_P_BW;
            STEP_P_BW:    n = STEP_T;
            STEP_T:       n = STEP_D_CPU;
            STEP_D_CPU:   n = STEP_D_RAM;
            STEP_D_RAM:   n = STEP_D_BW;
            STEP_D_BW:    n = STEP_P_CPU;
            STEP_DEN_BW:  n = STEP_DEN_RAM;
            STEP_DEN_RAM: n = STEP_Q_CPU;
            STEP_Q_CPU:   n = STEP_Q_RAM;
            STEP_Q_RAM:   n = STEP_Q_BW;
            STEP_Q_BW:    n = STEP_SQ_BW;
            STEP_SQ_BW:   n = STEP_SQ_RAM;
            STEP_SQ_RAM:  n = STEP_SQ_CPU;
            STEP_SQ_CPU:  n = STEP_SQ_BW;
            default:      n = STEP_P_CPU;
        endcase
        return n;
    endfunction

    function automatic logic signed [63:0] clamp_cap(input logic signed [63:0] v);
        logic signed [63:0] r;
        if (v > CAP) begin
            r = CAP;
        end else if (v < -CAP) begin
            r = -CAP;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[sv/lmsp_mul.sv]
// Shared 64x64 unsigned multiplier built from one 32x32 multiplier over four passes.
module lmsp_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg, b_reg;
    logic [1:0]   cnt_reg;
    logic         run_reg;
    logic         done_reg;
    logic [127:0] prod_reg;
    logic [31:0]  pa, pb;
    logic [63:0]  part;
    logic [127:0] part_sh;

    always_comb begin
        pa   = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
        pb   = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];
        part = 64'(pa) * 64'(pb);
        unique case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    part_sh = {64'b0, part};
            2'd1:    part_sh = {32'b0, part, 32'b0};
            2'd2:    part_sh = {part, 64'b0};
            default: part_sh = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= 2'd0;
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg    <= a;
            b_reg    <= b;
            prod_reg <= '0;
        end else if (run_reg) begin
            prod_reg <= prod_reg + part_sh;
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

[sv/lmsp_div.sv]
// Restoring divider giving num/den in Q.32, one quotient bit per cycle, clipped to the cap.
module lmsp_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [39:0]        num,
    input  logic [63:0]        den,
    output logic               done,
    output logic signed [63:0] quot
);

    logic [lmsp_pkg::Q_BITS-1:0] n_reg;
    logic [lmsp_pkg::Q_BITS-1:0] q_reg;
    logic [63:0]                 rem_reg;
    logic [63:0]                 den_reg;
    logic [6:0]                  cnt_reg;
    logic                        run_reg;
    logic                        done_reg;
    logic signed [63:0]          quot_reg;
    logic [63:0]                 r1;
    logic                        ge;
    logic [lmsp_pkg::Q_BITS-1:0] qf;

    always_comb begin
        r1 = {rem_reg[62:0], n_reg[lmsp_pkg::Q_BITS-1]};
        ge = (r1 >= den_reg);
        qf = {q_reg[lmsp_pkg::Q_BITS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= 7'd0;
                if (den == 64'd0) begin
                    done_reg <= 1'b1;
                end else begin
                    run_reg <= 1'b1;
                end
            end else if (run_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(lmsp_pkg::Q_BITS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg    <= {num, 32'b0};
            q_reg    <= '0;
            rem_reg  <= '0;
            den_reg  <= den;
            quot_reg <= lmsp_pkg::CAP;
        end else if (run_reg) begin
            n_reg   <= {n_reg[lmsp_pkg::Q_BITS-2:0], 1'b0};
            rem_reg <= ge ? r1 - den_reg : r1;
            q_reg   <= qf;
            if (cnt_reg == 7'(lmsp_pkg::Q_BITS - 1)) begin
                // clip a quotient at or above the cap
                if (qf[lmsp_pkg::Q_BITS-1:60] != '0) begin
                    quot_reg <= lmsp_pkg::CAP;
                end else begin
                    quot_reg <= $signed({4'b0, qf[59:0]});
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[sv/lms_load_predictor_score.sv]
// Top level of the LMS load predictor and placement score block.
//
// Keeps the latest bandwidth, RAM and CPU utilisation and four Q16.32 weights of a
// linear CPU predictor. A sample transaction (tuser bit 0 low) stores the new
// utilisations after one LMS step, or at once when first_sample is set; it gives no
// result. A query transaction (tuser bit 0 high) gives one result: the largest squared
// headroom in Q4.28, saturating with a flag. All arithmetic goes through one 32x32
// multiplier (four passes per product, with rounding and update after each product)
// and a restoring divider with one quotient bit per cycle. A query with allocated set
// uses two divisions and eight products. The input is not ready while an item is at
// work; a finished score waits in the output register.
module lms_load_predictor_score #(
    parameter int UTIL_FRAC_BITS = lmsp_pkg::UTIL_FRAC_BITS_DEF,
    parameter int WEIGHT_WIDTH   = lmsp_pkg::WEIGHT_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // bw_sample[15:0], ram_sample[31:16], cpu_sample[47:32],
    // stream_size[87:48], stream_length[119:88]
    input  logic [119:0] s_tdata,
    // action[0], first_sample[1], allocated[2]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // score[31:0]
    output logic [31:0]  m_tdata,
    // saturated[0]
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [63:0] WMAX_U  = (64'd1 << (WEIGHT_WIDTH - 1)) - 64'd1;
    localparam logic [63:0] WRST_U  = (WMAX_U < 64'h1_0000_0000) ? WMAX_U
                                                                 : 64'h1_0000_0000;
    localparam logic signed [WEIGHT_WIDTH-1:0] W_RST = WRST_U[WEIGHT_WIDTH-1:0];
    localparam logic signed [65:0] WMAX66 = $signed({2'b00, WMAX_U});
    localparam logic signed [65:0] WMIN66 = -WMAX66 - 66'sd1;

    function automatic logic signed [63:0] util_q32(input logic [15:0] u);
        return $signed({48'b0, u} << (lmsp_pkg::FRAC - UTIL_FRAC_BITS));
    endfunction

    function automatic logic signed [WEIGHT_WIDTH-1:0] wadd(
        input logic signed [WEIGHT_WIDTH-1:0] w,
        input logic signed [63:0]             d
    );
        logic signed [65:0] s;
        logic signed [WEIGHT_WIDTH-1:0] r;
        s = 66'(w) + 66'(d);
        if (s > WMAX66) begin
            r = WMAX66[WEIGHT_WIDTH-1:0];
        end else if (s < WMIN66) begin
            r = WMIN66[WEIGHT_WIDTH-1:0];
        end else begin
            r = s[WEIGHT_WIDTH-1:0];
        end
        return r;
    endfunction

    lmsp_pkg::state_t state_reg, state_next;
    lmsp_pkg::step_t  step_reg;

    logic [15:0] bw_now_reg, ram_now_reg, cpu_now_reg;
    logic signed [WEIGHT_WIDTH-1:0] wc_reg, wr_reg, wb_reg, wbias_reg;
    logic [31:0] tm_reg;
    logic [15:0] lr_reg;

    logic [15:0] bw_in_reg, ram_in_reg, cpu_in_reg;
    logic [39:0] size_reg;
    logic [31:0] len_reg;
    logic        alloc_reg;

    logic signed [63:0] acc_reg, e_reg, t_reg, bwt_reg, ramt_reg, pred_reg;
    logic signed [63:0] hb_reg, hr_reg, hc_reg, ms_reg;
    logic [31:0] sq_reg, best_reg;
    logic        sqsat_reg, anysat_reg;

    logic        m_tvalid_reg, m_sat_reg;
    logic [31:0] m_score_reg;

    logic        s_accept, mul_start, mul_done, div_start, div_done, out_load;
    logic [127:0] prod;
    logic signed [63:0] quot;

    logic signed [63:0] wc64, wr64, wb64, wbias64, bias_c;
    logic signed [63:0] xv, yv, zv, lrv;
    logic signed [63:0] opa, opb;
    logic [63:0] mag_a, mag_b;
    logic        neg;
    logic [127:0] q_full;
    logic        rem_nz, big, inc;
    logic [63:0] qc, qv;
    logic signed [63:0] ms_val, sum3;
    logic        sq_big;

    assign s_accept = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lmsp_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser[0] && s_tuser[1]) begin
                        state_next = lmsp_pkg::ST_IDLE;
                    end else begin
                        state_next = lmsp_pkg::ST_ISSUE;
                    end
                end
            end
            lmsp_pkg::ST_ISSUE: state_next = lmsp_pkg::ST_WAIT;
            lmsp_pkg::ST_WAIT: begin
                if (mul_done) begin
                    state_next = lmsp_pkg::ST_POST;
                end
            end
            lmsp_pkg::ST_POST: state_next = lmsp_pkg::ST_APPLY;
            lmsp_pkg::ST_APPLY: begin
                if (step_reg == lmsp_pkg::STEP_DEN_BW || step_reg == lmsp_pkg::STEP_DEN_RAM) begin
                    state_next = lmsp_pkg::ST_DIV;
                end else if (step_reg == lmsp_pkg::STEP_D_BW) begin
                    state_next = lmsp_pkg::ST_IDLE;
                end else if (step_reg == lmsp_pkg::STEP_SQ_CPU) begin
                    state_next = lmsp_pkg::ST_OUT;
                end else begin
                    state_next = lmsp_pkg::ST_ISSUE;
                end
            end
            lmsp_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = lmsp_pkg::ST_ISSUE;
                end
            end
            lmsp_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = lmsp_pkg::ST_IDLE;
                end
            end
            default: state_next = lmsp_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = (state_reg == lmsp_pkg::ST_IDLE);
        mul_start = (state_reg == lmsp_pkg::ST_ISSUE);
        div_start = (state_reg == lmsp_pkg::ST_APPLY) &&
                    (step_reg == lmsp_pkg::STEP_DEN_BW || step_reg == lmsp_pkg::STEP_DEN_RAM);
        out_load  = (state_reg == lmsp_pkg::ST_OUT) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmsp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // operand selection for the shared multiplier
    always_comb begin
        wc64    = 64'(wc_reg);
        wr64    = 64'(wr_reg);
        wb64    = 64'(wb_reg);
        wbias64 = 64'(wbias_reg);
        bias_c  = lmsp_pkg::clamp_cap(wbias64);
        xv      = $signed({48'b0, cpu_now_reg});
        yv      = $signed({48'b0, ram_now_reg});
        zv      = $signed({48'b0, bw_in_reg} - {48'b0, bw_now_reg});
        lrv     = $signed({48'b0, lr_reg});
        unique case (step_reg)
            lmsp_pkg::STEP_P_CPU:   begin opa = wc64;   opb = xv;  end
            lmsp_pkg::STEP_P_RAM:   begin opa = wr64;   opb = yv;  end
            lmsp_pkg::STEP_P_BW:    begin opa = wb64;   opb = zv;  end
            lmsp_pkg::STEP_T:       begin opa = e_reg;  opb = lrv; end
            lmsp_pkg::STEP_D_CPU:   begin opa = t_reg;  opb = xv;  end
            lmsp_pkg::STEP_D_RAM:   begin opa = t_reg;  opb = yv;  end
            lmsp_pkg::STEP_D_BW:    begin opa = t_reg;  opb = zv;  end
            lmsp_pkg::STEP_DEN_BW: begin
                opa = $signed({32'b0, len_reg});
                opb = $signed(lmsp_pkg::NS_PER_S);
            end
            lmsp_pkg::STEP_DEN_RAM: begin
                opa = $signed({32'b0, tm_reg});
                opb = $signed(lmsp_pkg::MEM_SCALE);
            end
            lmsp_pkg::STEP_Q_CPU:   begin opa = wc64;   opb = xv;      end
            lmsp_pkg::STEP_Q_RAM:   begin opa = wr64;   opb = yv;      end
            lmsp_pkg::STEP_Q_BW:    begin opa = wb64;   opb = bwt_reg; end
            lmsp_pkg::STEP_SQ_BW:   begin opa = hb_reg; opb = hb_reg;  end
            lmsp_pkg::STEP_SQ_RAM:  begin opa = hr_reg; opb = hr_reg;  end
            lmsp_pkg::STEP_SQ_CPU:  begin opa = hc_reg; opb = hc_reg;  end
            default:                begin opa = '0;     opb = '0;      end
        endcase
        neg   = opa[63] ^ opb[63];
        mag_a = opa[63] ? 64'(-opa) : 64'(opa);
        mag_b = opb[63] ? 64'(-opb) : 64'(opb);
    end

    lmsp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mag_a),
        .b       (mag_b),
        .done    (mul_done),
        .prod    (prod)
    );

    lmsp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (size_reg),
        .den     (prod[63:0]),
        .done    (div_done),
        .quot    (quot)
    );

    // floor of the signed product scaled down, clipped to the cap
    always_comb begin
        unique case (step_reg)
            lmsp_pkg::STEP_T: begin
                q_full = prod >> lmsp_pkg::LR_FRAC;
                rem_nz = (prod[lmsp_pkg::LR_FRAC-1:0] != '0);
            end
            lmsp_pkg::STEP_Q_BW: begin
                q_full = prod >> lmsp_pkg::FRAC;
                rem_nz = (prod[lmsp_pkg::FRAC-1:0] != '0);
            end
            default: begin
                q_full = prod >> UTIL_FRAC_BITS;
                rem_nz = (prod[UTIL_FRAC_BITS-1:0] != '0);
            end
        endcase
        big    = (q_full > {64'b0, lmsp_pkg::CAP});
        qc     = big ? 64'(lmsp_pkg::CAP) : q_full[63:0];
        inc    = neg && rem_nz && (qc < 64'(lmsp_pkg::CAP));
        qv     = qc + {63'b0, inc};
        ms_val = neg ? $signed(-qv) : $signed(qv);
        sum3   = acc_reg + ms_reg + bias_c;
        sq_big = (prod[127:lmsp_pkg::SQ_SHIFT+32] != '0);
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tm_reg <= lmsp_pkg::TOTAL_MEM_RST;
            lr_reg <= lmsp_pkg::LEARN_RATE_RST;
        end else if (cfg_valid) begin
            if (cfg_index == lmsp_pkg::REG_TOTAL_MEM) begin
                tm_reg <= cfg_data;
            end else if (cfg_index == lmsp_pkg::REG_LEARN_RATE) begin
                lr_reg <= cfg_data[15:0];
            end
        end
    end

    // predictor state and sequencer step
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bw_now_reg  <= '0;
            ram_now_reg <= '0;
            cpu_now_reg <= '0;
            wc_reg      <= W_RST;
            wr_reg      <= W_RST;
            wb_reg      <= W_RST;
            wbias_reg   <= W_RST;
            step_reg    <= lmsp_pkg::STEP_P_CPU;
        end else begin
            if (s_accept) begin
                if (s_tuser[0]) begin
                    step_reg <= s_tuser[2] ? lmsp_pkg::STEP_DEN_BW : lmsp_pkg::STEP_SQ_BW;
                end else begin
                    step_reg <= lmsp_pkg::STEP_P_CPU;
                    if (s_tuser[1]) begin
                        bw_now_reg  <= s_tdata[15:0];
                        ram_now_reg <= s_tdata[31:16];
                        cpu_now_reg <= s_tdata[47:32];
                    end
                end
            end else if (state_reg == lmsp_pkg::ST_DIV && div_done) begin
                step_reg <= lmsp_pkg::next_step(step_reg);
            end else if (state_reg == lmsp_pkg::ST_APPLY) begin
                if (step_reg != lmsp_pkg::STEP_DEN_BW && step_reg != lmsp_pkg::STEP_DEN_RAM) begin
                    step_reg <= lmsp_pkg::next_step(step_reg);
                end
                unique case (step_reg)
                    lmsp_pkg::STEP_D_CPU: wc_reg <= wadd(wc_reg, ms_reg);
                    lmsp_pkg::STEP_D_RAM: wr_reg <= wadd(wr_reg, ms_reg);
                    lmsp_pkg::STEP_D_BW: begin
                        wb_reg      <= wadd(wb_reg, ms_reg);
                        wbias_reg   <= wadd(wbias_reg, t_reg);
                        bw_now_reg  <= bw_in_reg;
                        ram_now_reg <= ram_in_reg;
                        cpu_now_reg <= cpu_in_reg;
                    end
                    default: ;
                endcase
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            bw_in_reg  <= s_tdata[15:0];
            ram_in_reg <= s_tdata[31:16];
            cpu_in_reg <= s_tdata[47:32];
            size_reg   <= s_tdata[87:48];
            len_reg    <= s_tdata[119:88];
            alloc_reg  <= s_tuser[2];
            hb_reg     <= lmsp_pkg::ONE - util_q32(bw_now_reg);
            hr_reg     <= lmsp_pkg::ONE - util_q32(ram_now_reg);
            hc_reg     <= lmsp_pkg::ONE - util_q32(cpu_now_reg);
        end
        if (state_reg == lmsp_pkg::ST_POST) begin
            ms_reg    <= ms_val;
            // clip an oversized square to the top score
            sq_reg    <= sq_big ? 32'hFFFF_FFFF
                                : prod[lmsp_pkg::SQ_SHIFT+31:lmsp_pkg::SQ_SHIFT];
            sqsat_reg <= sq_big;
        end
        if (state_reg == lmsp_pkg::ST_DIV && div_done) begin
            if (step_reg == lmsp_pkg::STEP_DEN_BW) begin
                bwt_reg <= quot;
            end else begin
                ramt_reg <= quot;
            end
        end
        if (state_reg == lmsp_pkg::ST_APPLY) begin
            unique case (step_reg)
                lmsp_pkg::STEP_P_CPU: acc_reg <= ms_reg;
                lmsp_pkg::STEP_P_RAM: acc_reg <= acc_reg + ms_reg;
                lmsp_pkg::STEP_P_BW:
                    e_reg <= lmsp_pkg::clamp_cap(util_q32(cpu_in_reg) - sum3);
                lmsp_pkg::STEP_T:     t_reg <= ms_reg;
                lmsp_pkg::STEP_Q_CPU: acc_reg <= ms_reg;
                lmsp_pkg::STEP_Q_RAM: acc_reg <= acc_reg + ms_reg;
                lmsp_pkg::STEP_Q_BW: begin
                    pred_reg <= lmsp_pkg::clamp_cap(sum3);
                    hb_reg   <= lmsp_pkg::clamp_cap(hb_reg - bwt_reg);
                    hr_reg   <= lmsp_pkg::clamp_cap(hr_reg - ramt_reg);
                end
                lmsp_pkg::STEP_SQ_BW: begin
                    best_reg   <= sq_reg;
                    anysat_reg <= sqsat_reg;
                    // take the predicted load off the CPU headroom before its square
                    if (alloc_reg) begin
                        hc_reg <= lmsp_pkg::clamp_cap(hc_reg - pred_reg);
                    end
                end
                lmsp_pkg::STEP_SQ_RAM, lmsp_pkg::STEP_SQ_CPU: begin
                    if (sq_reg > best_reg) begin
                        best_reg <= sq_reg;
                    end
                    anysat_reg <= anysat_reg | sqsat_reg;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_score_reg <= best_reg;
            m_sat_reg   <= anysat_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_score_reg;
    assign m_tuser[0] = m_sat_reg;

endmodule

[tb/tb_lms_load_predictor_score.sv]
// Self-checking testbench for the LMS load predictor and placement score block.
module tb_lms_load_predictor_score;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [127:0] CAP_W     = 128'h1000_0000_0000_0000;
    localparam longint       W_MAX     = (64'sd1 <<< 47) - 1;
    localparam longint       W_MIN     = -W_MAX - 1;
    localparam int           SETTLE    = 400;
    localparam int           LONG_HOLD = 3000;

    typedef struct packed {
        logic [31:0] score;
        logic        saturated;
    } score_t;

    typedef struct packed {
        logic        action;
        logic        first_sample;
        logic [15:0] bw;
        logic [15:0] ram;
        logic [15:0] cpu;
        logic        allocated;
        logic [39:0] size;
        logic [31:0] length;
    } load_item_t;

    class score_board;
        logic [15:0] bw_now, ram_now, cpu_now;
        longint      w_cpu, w_ram, w_bw, w_bias;
        logic [31:0] total_mem;
        logic [15:0] learn_rate;
        score_t      pending_scores[$];
        int          errors;

        function new();
            bw_now = 0;
            ram_now = 0;
            cpu_now = 0;
            w_cpu = lmsp_pkg::ONE;
            w_ram = lmsp_pkg::ONE;
            w_bw = lmsp_pkg::ONE;
            w_bias = lmsp_pkg::ONE;
            total_mem = lmsp_pkg::TOTAL_MEM_RST;
            learn_rate = lmsp_pkg::LEARN_RATE_RST;
            errors = 0;
        endfunction

        task report(input string what, input logic [31:0] got, input logic [31:0] want);
            errors++;
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        endtask

        function longint cap(input longint v);
            if (v > lmsp_pkg::CAP) return lmsp_pkg::CAP;
            if (v < -lmsp_pkg::CAP) return -lmsp_pkg::CAP;
            return v;
        endfunction

        // floor(a*b / 2^s), clipped to the internal range
        function longint floor_mul(input longint a, input longint b, input int s);
            logic [63:0]  ma, mb;
            logic [127:0] p, q;
            bit           neg, rem;
            neg = (a < 0) != (b < 0);
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            p = {64'd0, ma} * {64'd0, mb};
            rem = (p & ((128'd1 << s) - 128'd1)) != 0;
            q = p >> s;
            if (q > CAP_W) q = CAP_W;
            if (neg && rem && q < CAP_W) q = q + 1;
            return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        endfunction

        function longint quo_q32(input logic [63:0] num, input logic [63:0] den);
            logic [127:0] r;
            if (den == 0) return lmsp_pkg::CAP;
            if (num / den >= (64'd1 << 28)) return lmsp_pkg::CAP;
            r = ({64'd0, num} << 32) / {64'd0, den};
            return longint'(r[63:0]);
        endfunction

        function logic [32:0] square_q28(input longint h);
            logic [63:0]  m;
            logic [127:0] p;
            m = (h < 0) ? -h : h;
            p = ({64'd0, m} * {64'd0, m}) >> lmsp_pkg::SQ_SHIFT;
            if (p > 128'hFFFF_FFFF) return {1'b1, 32'hFFFF_FFFF};
            return {1'b0, p[31:0]};
        endfunction

        function longint w_add(input longint w, input longint d);
            longint s;
            s = w + d;
            if (s > W_MAX) return W_MAX;
            if (s < W_MIN) return W_MIN;
            return s;
        endfunction

        function longint util_q32(input logic [15:0] u);
            return longint'(u) <<< 17;
        endfunction

        function void write_reg(input logic [7:0] idx, input logic [31:0] val);
            if (idx == lmsp_pkg::REG_TOTAL_MEM) total_mem = val;
            else if (idx == lmsp_pkg::REG_LEARN_RATE) learn_rate = val[15:0];
        endfunction

        function void note_input(input load_item_t it);
            longint x, y, z, p, e, t, hb, hr, hc, bwt, ramt, pred;
            logic [32:0] sb, sr, sc, best;
            score_t res;
            if (!it.action) begin
                if (!it.first_sample) begin
                    x = longint'(cpu_now);
                    y = longint'(ram_now);
                    z = longint'(it.bw) - longint'(bw_now);
                    p = floor_mul(w_cpu, x, 15) + floor_mul(w_ram, y, 15)
                        + floor_mul(w_bw, z, 15) + cap(w_bias);
                    e = cap(util_q32(it.cpu) - p);
                    t = floor_mul(e, longint'(learn_rate), lmsp_pkg::LR_FRAC);
                    w_cpu = w_add(w_cpu, floor_mul(t, x, 15));
                    w_ram = w_add(w_ram, floor_mul(t, y, 15));
                    w_bw = w_add(w_bw, floor_mul(t, z, 15));
                    w_bias = w_add(w_bias, t);
                end
                bw_now = it.bw;
                ram_now = it.ram;
                cpu_now = it.cpu;
            end else begin
                hb = lmsp_pkg::ONE - util_q32(bw_now);
                hr = lmsp_pkg::ONE - util_q32(ram_now);
                hc = lmsp_pkg::ONE - util_q32(cpu_now);
                if (it.allocated) begin
                    bwt = quo_q32(64'(it.size), 64'(it.length) * lmsp_pkg::NS_PER_S);
                    ramt = quo_q32(64'(it.size), 64'(total_mem) * lmsp_pkg::MEM_SCALE);
                    pred = cap(floor_mul(w_cpu, longint'(cpu_now), 15)
                        + floor_mul(w_ram, longint'(ram_now), 15)
                        + floor_mul(w_bw, bwt, lmsp_pkg::FRAC) + cap(w_bias));
                    hb = cap(hb - bwt);
                    hr = cap(hr - ramt);
                    hc = cap(hc - pred);
                end
                sb = square_q28(hb);
                sr = square_q28(hr);
                sc = square_q28(hc);
                best = sb;
                if (sr[31:0] > best[31:0]) best = sr;
                if (sc[31:0] > best[31:0]) best = sc;
                res.score = best[31:0];
                res.saturated = sb[32] | sr[32] | sc[32];
                pending_scores.push_back(res);
            end
        endfunction

        task check_result(input logic [31:0] score, input logic sat);
            score_t want;
            if (pending_scores.size() == 0) begin
                report("unexpected score", score, 32'd0);
            end else begin
                want = pending_scores.pop_front();
                if (score !== want.score) report("score", score, want.score);
                if (sat !== want.saturated) report("saturated", 32'(sat), 32'(want.saturated));
            end
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [31:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    score_board sb = new();
    bit         idle_on = 1;
    bit         hold_req = 0;

    lms_load_predictor_score i_dut (.*);

    always #2 aclk = ~aclk;

    task automatic send_item(input load_item_t it);
        int gap;
        gap = idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {it.length, it.size, it.cpu, it.ram, it.bw};
        s_tuser <= {it.allocated, it.first_sample, it.action};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(it);
    endtask

    task automatic write_cfg(input logic [7:0] idx, input logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // drop valid, wait for every score and let a trailing sample finish
    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic load_item_t mk(input bit act, input bit first, input logic [15:0] bw,
                                      input logic [15:0] ram, input logic [15:0] cpu,
                                      input bit alloc, input logic [39:0] size,
                                      input logic [31:0] len);
        load_item_t it;
        it.action = act;
        it.first_sample = first;
        it.bw = bw;
        it.ram = ram;
        it.cpu = cpu;
        it.allocated = alloc;
        it.size = size;
        it.length = len;
        return it;
    endfunction

    function automatic logic [15:0] rand_util();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [39:0] rand_size();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 40'($urandom_range(0, 100000));
            default: return {8'($urandom), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return '1;
            3: return 32'($urandom_range(1, 1000));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic load_item_t rand_item();
        bit act;
        act = $urandom_range(0, 1);
        return mk(act, ($urandom_range(0, 9) == 0), rand_util(), rand_util(), rand_util(),
                  act ? ($urandom_range(0, 9) < 6) : $urandom_range(0, 1),
                  rand_size(), rand_len());
    endfunction

    // result side: random stalls, one long hold-off on request
    initial begin
        int w;
        @(posedge aresetn);
        @(posedge aclk);
        forever begin
            w = idle_on ? $urandom_range(0, 12) : 0;
            if (hold_req) begin
                hold_req = 0;
                w = LONG_HOLD;
            end
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser[0]);
        end
    end

    initial begin
        logic [31:0] mem_set[6];
        logic [15:0] rate_set[6];
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset state, extremes, over-one utilisation, zero length, huge cost
        send_item(mk(1, 0, 0, 0, 0, 0, 0, 1));
        send_item(mk(1, 0, 0, 0, 0, 1, 0, 1));
        send_item(mk(0, 1, 0, 0, 0, 0, 0, 0));
        send_item(mk(1, 0, 0, 0, 0, 1, '1, 0));
        send_item(mk(0, 1, 16'd32768, 16'd32768, 16'd32768, 1, '1, '1));
        send_item(mk(1, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(1, 1, 0, 0, 0, 1, 40'd12345, 32'd7));
        send_item(mk(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0));
        send_item(mk(1, 0, 0, 0, 0, 0, 0, 0));
        send_item(mk(1, 0, 0, 0, 0, 1, '1, 32'd1));
        send_item(mk(0, 0, 0, 16'd32768, 0, 0, 0, 0));
        send_item(mk(1, 0, 0, 0, 0, 1, 40'd5_000_000_000, 32'd3));
        send_item(mk(0, 0, 16'd16384, 16'd100, 16'd30000, 1, '1, '1));
        send_item(mk(1, 1, 0, 0, 0, 1, '1, '1));
        drain();
        write_cfg(8'd5, '1);
        write_cfg(lmsp_pkg::REG_LEARN_RATE, 32'hFFFF_0000);
        send_item(mk(1, 0, 0, 0, 0, 1, 40'd777, 32'd2));
        send_item(mk(0, 0, 16'd1, 16'd2, 16'd3, 0, 0, 0));
        send_item(mk(1, 0, 0, 0, 0, 1, 40'd777, 32'd2));
        drain();

        mem_set = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'($urandom), 32'd1000,
                    32'($urandom_range(1, 64))};
        rate_set = '{16'd655, 16'hFFFF, 16'd0, 16'($urandom), 16'd1, 16'd655};
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(lmsp_pkg::REG_TOTAL_MEM, mem_set[ph]);
            write_cfg(lmsp_pkg::REG_LEARN_RATE, 32'(rate_set[ph]));
            idle_on = (ph != 2);
            for (int i = 0; i < 230; i++) begin
                if (ph == 1 && i == 40) hold_req = 1;
                send_item(rand_item());
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
sv/lmsp_pkg.sv
sv/lmsp_mul.sv
sv/lmsp_div.sv
sv/lms_load_predictor_score.sv
tb/tb_lms_load_predictor_score.sv
